@@ hdl/vme_pkg.sv @@
// ----------------------------------------------------------------------------
// vme_pkg
// Shared types and constants for the majority element unit: payload structs,
// controller states and the command/status groups between the two halves.
// ----------------------------------------------------------------------------
package vme_pkg;

   // Capacity of the element buffer and the number of value bits that take part.
   localparam int MAX_ITEMS  = 1024;
   localparam int DATA_WIDTH = 32;   // must not exceed VALUE_W

   localparam int VALUE_W = 32;
   localparam int MATCH_W = 11;
   localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] majority_value;
      logic                      found;
      logic [MATCH_W-1:0]        match_count;
      logic                      overflow;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;     // store and vote on the request at the input
      logic scan_read;  // read the next stored element for the count
      logic emit;       // load the result register and clear the set
   } ctrl_cmd_type;

   typedef struct packed {
      logic overflow_now;  // set is already too long, or this request overflows it
      logic scan_last;     // current read address is the final stored element
      logic out_free;      // result register can take a new result this cycle
   } dp_status_type;

endpackage

@@ hdl/vme_ctrl.sv @@
// ----------------------------------------------------------------------------
// vme_ctrl
// Sequencer for the majority element unit: loads a set, runs the counting
// pass over the buffer and hands the result to the output register.
// ----------------------------------------------------------------------------
module vme_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_last,
   output logic                   req_ready,
   input  vme_pkg::dp_status_type status,
   output vme_pkg::ctrl_cmd_type  cmd
);

   vme_pkg::state_type state_ff;
   vme_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vme_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vme_pkg::ST_LOAD: begin
            if (req_valid && req_last) begin
               // An overflowed set has a fixed result, so the count is skipped.
               state_in = status.overflow_now ? vme_pkg::ST_EMIT : vme_pkg::ST_SCAN;
            end
         end
         vme_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = vme_pkg::ST_DRAIN;
            end
         end
         vme_pkg::ST_DRAIN: begin
            state_in = vme_pkg::ST_EMIT;
         end
         vme_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = vme_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = vme_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.scan_read = 1'b0;
      cmd.emit      = 1'b0;
      case (state_ff)
         vme_pkg::ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         vme_pkg::ST_SCAN: begin
            cmd.scan_read = 1'b1;
         end
         vme_pkg::ST_DRAIN: begin
            cmd.scan_read = 1'b0;
         end
         vme_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/vme_datapath.sv @@
// ----------------------------------------------------------------------------
// vme_datapath
// Element buffer, vote registers, counting pass and the result register of
// the majority element unit.
// ----------------------------------------------------------------------------
module vme_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  vme_pkg::req_payload_type req_data,
   input  vme_pkg::ctrl_cmd_type    cmd,
   output vme_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vme_pkg::rsp_payload_type rsp_data
);

   logic [vme_pkg::DATA_WIDTH-1:0] mem [vme_pkg::MAX_ITEMS];

   logic [vme_pkg::DATA_WIDTH-1:0] cand_ff, cand_in;
   logic [vme_pkg::CNT_W-1:0]      vote_ff, vote_in;
   logic [vme_pkg::CNT_W-1:0]      item_ff, item_in;
   logic [vme_pkg::CNT_W-1:0]      tally_ff, tally_in;
   logic                           ovf_ff, ovf_in;
   logic [vme_pkg::ADDR_W-1:0]     rd_addr_ff, rd_addr_in;
   logic                           rd_valid_ff;
   logic [vme_pkg::DATA_WIDTH-1:0] rd_data_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   vme_pkg::rsp_payload_type       rsp_ff, rsp_in;

   logic [vme_pkg::DATA_WIDTH-1:0] v;
   logic                           full;
   logic                           do_store;
   logic [vme_pkg::CNT_W-1:0]      vote_step;
   logic                           found;

   assign v        = req_data.value[vme_pkg::DATA_WIDTH-1:0];
   assign full     = (item_ff == vme_pkg::CNT_W'(vme_pkg::MAX_ITEMS));
   assign do_store = cmd.accept && !full;
   assign found    = ({tally_ff, 1'b0} > {1'b0, item_ff});

   assign status.overflow_now = ovf_ff || full;
   assign status.scan_last    = (vme_pkg::CNT_W'(rd_addr_ff) + vme_pkg::CNT_W'(1)) == item_ff;
   assign status.out_free     = !rsp_valid_ff || rsp_ready;

   // Buffer: one write port for loading, one registered read port for the count.
   always_ff @(posedge clock) begin
      if (do_store) begin
         mem[item_ff[vme_pkg::ADDR_W-1:0]] <= v;
      end
      if (cmd.scan_read) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

   always_comb begin
      cand_in   = cand_ff;
      vote_in   = vote_ff;
      item_in   = item_ff;
      ovf_in    = ovf_ff;
      vote_step = (v == cand_ff) ? vote_ff + vme_pkg::CNT_W'(1) : vote_ff - vme_pkg::CNT_W'(1);
      if (cmd.accept) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            item_in = item_ff + vme_pkg::CNT_W'(1);
            // A vote that falls to zero hands the candidacy to this element.
            if (item_ff == '0 || vote_step == '0) begin
               cand_in = v;
               vote_in = vme_pkg::CNT_W'(1);
            end else begin
               vote_in = vote_step;
            end
         end
      end
      if (cmd.emit) begin
         cand_in = '0;
         vote_in = '0;
         item_in = '0;
         ovf_in  = 1'b0;
      end
   end

   always_comb begin
      rd_addr_in = rd_addr_ff;
      tally_in   = tally_ff;
      if (cmd.scan_read) begin
         rd_addr_in = rd_addr_ff + vme_pkg::ADDR_W'(1);
      end
      if (rd_valid_ff && rd_data_ff == cand_ff) begin
         tally_in = tally_ff + vme_pkg::CNT_W'(1);
      end
      if (cmd.emit) begin
         rd_addr_in = '0;
         tally_in   = '0;
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (ovf_ff) begin
            rsp_in.majority_value = '0;
            rsp_in.found          = 1'b0;
            rsp_in.match_count    = '0;
            rsp_in.overflow       = 1'b1;
         end else begin
            rsp_in.majority_value = found ? vme_pkg::VALUE_W'(signed'(cand_ff)) : '0;
            rsp_in.found          = found;
            rsp_in.match_count    = vme_pkg::MATCH_W'(tally_ff);
            rsp_in.overflow       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff      <= '0;
         vote_ff      <= '0;
         item_ff      <= '0;
         tally_ff     <= '0;
         ovf_ff       <= 1'b0;
         rd_addr_ff   <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cand_ff      <= cand_in;
         vote_ff      <= vote_in;
         item_ff      <= item_in;
         tally_ff     <= tally_in;
         ovf_ff       <= ovf_in;
         rd_addr_ff   <= rd_addr_in;
         rd_valid_ff  <= cmd.scan_read;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // The controller must never overwrite a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while occupied");

   assert property (@(posedge clock) disable iff (reset)
      vote_ff <= item_ff && tally_ff <= item_ff)
      else $error("vote or tally exceeds the number of stored elements");

   assert property (@(posedge clock) disable iff (reset)
      item_ff <= vme_pkg::CNT_W'(vme_pkg::MAX_ITEMS))
      else $error("element count beyond buffer capacity");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> !rsp_ff.overflow)
      else $error("majority reported for an overflowed set");

   // No read is issued past the stored elements of the current set.
   assert property (@(posedge clock) disable iff (reset)
      cmd.scan_read |-> (vme_pkg::CNT_W'(rd_addr_ff) < item_ff))
      else $error("counting pass reads beyond the stored set");

endmodule

@@ hdl/verified_majority_element_unit.sv @@
// After the last request of a set is taken, the controller reads the stored elements
// in SCAN, passes DRAIN and loads the result register in EMIT once it is free; an
// overflowed set goes straight to EMIT. Loading takes one request per cycle; the
// counting pass reads the buffer through its single read port, one element a cycle.
// Reset (synchronous, active high) clears the controller, the vote registers and the
// result handshake; the element buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// verified_majority_element_unit
// Majority vote over a set of signed values with a verifying count pass over
// the stored set.
// ----------------------------------------------------------------------------
module verified_majority_element_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vme_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vme_pkg::rsp_payload_type rsp_data
);

   vme_pkg::ctrl_cmd_type  cmd;
   vme_pkg::dp_status_type status;

   vme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vme_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
